[rtl/core/bpt_pkg.sv]
package bpt_pkg;

  localparam int RawW      = 24;
  localparam int CoefW     = 16;
  localparam int CfgIdxW   = 3;
  localparam int DtW       = 25;  // raw_t - tref*256, signed
  localparam int MulW      = 41;  // dT * 16-bit coefficient, signed
  localparam int OffW      = 37;
  localparam int SensW     = 35;
  localparam int SensLoW   = 17;
  localparam int SensHiW   = SensW - SensLoW;
  localparam int PpLoW     = RawW + SensLoW;
  localparam int PpHiW     = RawW + 1 + SensHiW;
  localparam int ProdW     = 60;
  localparam int Q1W       = ProdW - 21;
  localparam int DiffW     = Q1W + 1;
  localparam int TempW     = 19;
  localparam int PresW     = 24;

  localparam int OffScale      = 18;
  localparam int SensScale     = 17;
  localparam int OffTcShift    = 5;
  localparam int SensTcShift   = 7;
  localparam int TempDivShift  = 23;
  localparam int PresDiv1Shift = 21;
  localparam int PresDiv2Shift = 15;
  localparam int TempBase      = 2000;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CoefPresSens   = 3'd0;
  localparam logic [CfgIdxW-1:0] CoefPresOffset = 3'd1;
  localparam logic [CfgIdxW-1:0] CoefTcs        = 3'd2;
  localparam logic [CfgIdxW-1:0] CoefTco        = 3'd3;
  localparam logic [CfgIdxW-1:0] CoefTref       = 3'd4;
  localparam logic [CfgIdxW-1:0] CoefTempsens   = 3'd5;

  typedef struct packed {
    logic [CoefW-1:0] pres_sens;
    logic [CoefW-1:0] pres_offset;
    logic [CoefW-1:0] tcs;
    logic [CoefW-1:0] tco;
    logic [CoefW-1:0] tref;
    logic [CoefW-1:0] tempsens;
  } coef_t;

  // handoff from the front section to the pressure section
  typedef struct packed {
    logic signed [OffW-1:0]  off;
    logic signed [SensW-1:0] sens;
    logic [RawW-1:0]         raw_pres;
    logic signed [TempW-1:0] temp;
  } comp_t;

endpackage

[rtl/core/bpt_coef_regs.sv]
module bpt_coef_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bpt_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [bpt_pkg::CoefW-1:0]     cfg_data,
  output bpt_pkg::coef_t                coef
);

  bpt_pkg::coef_t coef_r;
  bpt_pkg::coef_t coef_nxt;

  assign cfg_ready = 1'b1;
  assign coef      = coef_r;

  always_comb begin
    coef_nxt = coef_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        bpt_pkg::CoefPresSens:   coef_nxt.pres_sens   = cfg_data;
        bpt_pkg::CoefPresOffset: coef_nxt.pres_offset = cfg_data;
        bpt_pkg::CoefTcs:        coef_nxt.tcs         = cfg_data;
        bpt_pkg::CoefTco:        coef_nxt.tco         = cfg_data;
        bpt_pkg::CoefTref:       coef_nxt.tref        = cfg_data;
        bpt_pkg::CoefTempsens:   coef_nxt.tempsens    = cfg_data;
        default: ;  // unknown index: write dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= '0;
    end else begin
      coef_r <= coef_nxt;
    end
  end

endmodule

[rtl/core/bpt_front.sv]
// Stages 1-3: dT, the three dT products, then OFF / SENS / TEMP.
module bpt_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  bpt_pkg::coef_t            coef,
  input  logic                      up_valid,
  output logic                      up_ready,
  input  logic [bpt_pkg::RawW-1:0]  up_raw_pres,
  input  logic [bpt_pkg::RawW-1:0]  up_raw_temp,
  output logic                      dn_valid,
  input  logic                      dn_ready,
  output bpt_pkg::comp_t            dn_data
);

  logic rdy1, rdy2, rdy3;

  // stage 1
  logic                             v1_r;
  logic signed [bpt_pkg::DtW-1:0]   dt1_r;
  logic signed [bpt_pkg::DtW-1:0]   dt1_nxt;
  logic [bpt_pkg::RawW-1:0]         rawp1_r;

  // stage 2
  logic                             v2_r;
  logic signed [bpt_pkg::MulW-1:0]  moff2_r, msens2_r, mtemp2_r;
  logic signed [bpt_pkg::MulW-1:0]  moff2_nxt, msens2_nxt, mtemp2_nxt;
  logic [bpt_pkg::RawW-1:0]         rawp2_r;

  // stage 3
  logic                             v3_r;
  bpt_pkg::comp_t                   comp3_r;
  bpt_pkg::comp_t                   comp3_nxt;

  logic signed [bpt_pkg::MulW-1:0]  tsum;
  logic signed [bpt_pkg::TempW-1:0] tquot;

  assign rdy3     = !v3_r || dn_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign up_ready = rdy1;
  assign dn_valid = v3_r;
  assign dn_data  = comp3_r;

  assign dt1_nxt = $signed({1'b0, up_raw_temp}) - $signed({1'b0, coef.tref, 8'b0});

  assign moff2_nxt  = dt1_r * $signed({1'b0, coef.tco});
  assign msens2_nxt = dt1_r * $signed({1'b0, coef.tcs});
  assign mtemp2_nxt = dt1_r * $signed({1'b0, coef.tempsens});

  // truncate toward zero: bias negatives by 2^23-1 before dropping bits
  assign tsum  = mtemp2_r + (mtemp2_r[bpt_pkg::MulW-1] ?
                 bpt_pkg::MulW'((64'd1 << bpt_pkg::TempDivShift) - 64'd1) :
                 bpt_pkg::MulW'(0));
  assign tquot = {tsum[bpt_pkg::MulW-1], tsum[bpt_pkg::MulW-1:bpt_pkg::TempDivShift]};

  always_comb begin
    comp3_nxt.off = $signed({3'b0, coef.pres_offset, bpt_pkg::OffScale'(0)})
                  + $signed({moff2_r[bpt_pkg::MulW-1],
                             moff2_r[bpt_pkg::MulW-1:bpt_pkg::OffTcShift]});
    comp3_nxt.sens = $signed({2'b0, coef.pres_sens, bpt_pkg::SensScale'(0)})
                   + $signed({msens2_r[bpt_pkg::MulW-1],
                              msens2_r[bpt_pkg::MulW-1:bpt_pkg::SensTcShift]});
    comp3_nxt.raw_pres = rawp2_r;
    comp3_nxt.temp     = tquot + bpt_pkg::TempW'(bpt_pkg::TempBase);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= up_valid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      dt1_r   <= dt1_nxt;
      rawp1_r <= up_raw_pres;
    end
    if (rdy2) begin
      moff2_r  <= moff2_nxt;
      msens2_r <= msens2_nxt;
      mtemp2_r <= mtemp2_nxt;
      rawp2_r  <= rawp1_r;
    end
    if (rdy3) begin
      comp3_r <= comp3_nxt;
    end
  end

endmodule

[rtl/core/bpt_pres.sv]
// Stages 4-7: raw_pres*SENS as two partial products, recombine,
// truncating /2^21, subtract OFF and truncating /2^15.
module bpt_pres (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              up_valid,
  output logic                              up_ready,
  input  bpt_pkg::comp_t                    up_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [bpt_pkg::PresW-1:0]  out_pres,
  output logic signed [bpt_pkg::TempW-1:0]  out_temp
);

  logic rdy4, rdy5, rdy6, rdy7;

  // stage 4
  logic                              v4_r;
  logic [bpt_pkg::PpLoW-1:0]         pplo4_r;
  logic signed [bpt_pkg::PpHiW-1:0]  pphi4_r;
  logic signed [bpt_pkg::OffW-1:0]   off4_r;
  logic signed [bpt_pkg::TempW-1:0]  temp4_r;
  logic signed [bpt_pkg::SensHiW-1:0] sens_hi;
  logic [bpt_pkg::SensLoW-1:0]       sens_lo;

  // stage 5
  logic                              v5_r;
  logic signed [bpt_pkg::ProdW-1:0]  prod5_r;
  logic signed [bpt_pkg::ProdW-1:0]  prod5_nxt;
  logic signed [bpt_pkg::OffW-1:0]   off5_r;
  logic signed [bpt_pkg::TempW-1:0]  temp5_r;

  // stage 6
  logic                              v6_r;
  logic signed [bpt_pkg::Q1W-1:0]    q6_r;
  logic signed [bpt_pkg::ProdW-1:0]  psum;
  logic signed [bpt_pkg::OffW-1:0]   off6_r;
  logic signed [bpt_pkg::TempW-1:0]  temp6_r;

  // stage 7 (output register)
  logic                              v7_r;
  logic signed [bpt_pkg::PresW-1:0]  pres7_r;
  logic signed [bpt_pkg::TempW-1:0]  temp7_r;
  logic signed [bpt_pkg::DiffW-1:0]  diff;
  logic signed [bpt_pkg::DiffW-1:0]  dsum;

  assign rdy7      = !v7_r || out_ready;
  assign rdy6      = !v6_r || rdy7;
  assign rdy5      = !v5_r || rdy6;
  assign rdy4      = !v4_r || rdy5;
  assign up_ready  = rdy4;
  assign out_valid = v7_r;
  assign out_pres  = pres7_r;
  assign out_temp  = temp7_r;

  assign sens_lo = up_data.sens[bpt_pkg::SensLoW-1:0];
  assign sens_hi = up_data.sens[bpt_pkg::SensW-1:bpt_pkg::SensLoW];

  assign prod5_nxt = $signed({pphi4_r, bpt_pkg::SensLoW'(0)})
                   + $signed({(bpt_pkg::ProdW - bpt_pkg::PpLoW)'(0), pplo4_r});

  assign psum = prod5_r + (prod5_r[bpt_pkg::ProdW-1] ?
                bpt_pkg::ProdW'((64'd1 << bpt_pkg::PresDiv1Shift) - 64'd1) :
                bpt_pkg::ProdW'(0));

  assign diff = bpt_pkg::DiffW'(q6_r) - bpt_pkg::DiffW'(off6_r);
  assign dsum = diff + (diff[bpt_pkg::DiffW-1] ?
                bpt_pkg::DiffW'((64'd1 << bpt_pkg::PresDiv2Shift) - 64'd1) :
                bpt_pkg::DiffW'(0));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
    end else begin
      if (rdy4) begin
        v4_r <= up_valid;
      end
      if (rdy5) begin
        v5_r <= v4_r;
      end
      if (rdy6) begin
        v6_r <= v5_r;
      end
      if (rdy7) begin
        v7_r <= v6_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      pplo4_r <= up_data.raw_pres * sens_lo;
      pphi4_r <= $signed({1'b0, up_data.raw_pres}) * sens_hi;
      off4_r  <= up_data.off;
      temp4_r <= up_data.temp;
    end
    if (rdy5) begin
      prod5_r <= prod5_nxt;
      off5_r  <= off4_r;
      temp5_r <= temp4_r;
    end
    if (rdy6) begin
      q6_r    <= psum[bpt_pkg::ProdW-1:bpt_pkg::PresDiv1Shift];
      off6_r  <= off5_r;
      temp6_r <= temp5_r;
    end
    if (rdy7) begin
      pres7_r <= dsum[bpt_pkg::PresDiv2Shift+bpt_pkg::PresW-1:bpt_pkg::PresDiv2Shift];
      temp7_r <= temp6_r;
    end
  end

endmodule

[rtl/core/baro_pressure_temp_compensation.sv]
// Barometer first-order pressure / temperature compensation.
//
// Input channel (in_valid/in_ready): one transaction carries a raw 24-bit
// pressure and a raw 24-bit temperature conversion. Output channel
// (out_valid/out_ready): one transaction per input, pressure in pascals
// (24-bit signed) and temperature in 0.01 degree (19-bit signed).
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): writes the six
// calibration words, index 0..5 in PROM order; other indexes are dropped.
// cfg_ready is always high. Write coefficients only while the pipe is empty.
//
// Throughput: one transaction per cycle unless the output stalls; each of
// the 7 pipeline stages holds one item and the widest step per stage is
// one 25x18 multiply or one ~60-bit add.
// Reset (rst_n low, synchronous) empties the pipe and clears the
// calibration words to zero.
// Output stall: each stage's ready is !valid || next ready, so bubbles
// collapse; a stalled output holds its data and the pipe keeps accepting
// until all 7 stages are full, then in_ready drops.
module baro_pressure_temp_compensation (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [bpt_pkg::RawW-1:0]          in_raw_pressure,
  input  logic [bpt_pkg::RawW-1:0]          in_raw_temperature,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [bpt_pkg::PresW-1:0]  out_pressure_pa,
  output logic signed [bpt_pkg::TempW-1:0]  out_temp_centideg,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bpt_pkg::CfgIdxW-1:0]       cfg_index,
  input  logic [bpt_pkg::CoefW-1:0]         cfg_data
);

  localparam int PipeDepth = 7;

  bpt_pkg::coef_t coef;
  bpt_pkg::comp_t comp;
  logic           comp_valid;
  logic           comp_ready;

  // items in flight, used by the checks below
  logic [3:0] occ_r;
  logic [3:0] occ_nxt;

  bpt_coef_regs u_coef (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coef      (coef)
  );

  // stages 1-3: dT, products with the temperature coefficients, OFF/SENS/TEMP
  bpt_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .coef        (coef),
    .up_valid    (in_valid),
    .up_ready    (in_ready),
    .up_raw_pres (in_raw_pressure),
    .up_raw_temp (in_raw_temperature),
    .dn_valid    (comp_valid),
    .dn_ready    (comp_ready),
    .dn_data     (comp)
  );

  // stages 4-7: raw pressure times SENS, scaling, OFF subtraction
  bpt_pres u_pres (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (comp_valid),
    .up_ready  (comp_ready),
    .up_data   (comp),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_pres  (out_pressure_pa),
    .out_temp  (out_temp_centideg)
  );

  assign occ_nxt = occ_r + 4'(in_valid && in_ready) - 4'(out_valid && out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  a_no_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("pipe stalls input while sink is ready");

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= 4'(PipeDepth))
    else $error("more items in flight than pipeline stages");

  a_out_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> occ_r != 4'd0)
    else $error("result presented with no item in flight");

endmodule
